// ----- src/bloom_filter_double_hash_core_macros.svh -----
// Assertion helpers shared by the modules of the bloom filter core.
// Each module that uses them has signals named clk and rst_n.
`ifndef BLOOM_FILTER_DOUBLE_HASH_CORE_MACROS_SVH
`define BLOOM_FILTER_DOUBLE_HASH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFDH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfdh assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFDH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfdh assertion failed");

`endif

// ----- src/bfdh_pkg.sv -----
package bfdh_pkg;

    localparam int MAX_BITS      = 65536;
    localparam int MAX_HASHES    = 16;
    localparam int MAX_KEY_BYTES = 65535;

    localparam logic [31:0] HASH_SEED = 32'hdeadbeef;
    localparam logic [31:0] MUR_C1    = 32'hcc9e2d51;
    localparam logic [31:0] MUR_C2    = 32'h1b873593;
    localparam logic [31:0] MUR_N     = 32'he6546b64;
    localparam logic [31:0] MUR_F1    = 32'h85ebca6b;
    localparam logic [31:0] MUR_F2    = 32'hc2b2ae35;

    // Fixed field widths of the ports.
    localparam int CFG_BITS_W = 17;
    localparam int CFG_HASH_W = 5;
    localparam int COUNT_W    = 17;

    // Derived widths.
    localparam int POS_W    = $clog2(MAX_BITS);
    localparam int SIZE_W   = POS_W + 1;
    localparam int HC_W     = $clog2(MAX_HASHES) + 1;
    localparam int KL_W     = $clog2(MAX_KEY_BYTES + 1);
    localparam int WC_W     = KL_W - 1;
    localparam int KW_DEPTH = (MAX_KEY_BYTES + 3) / 4;
    localparam int KW_AW    = $clog2(KW_DEPTH);
    localparam int BM_DEPTH = MAX_BITS / 32;
    localparam int BM_AW    = $clog2(BM_DEPTH);

    typedef enum logic [1:0] {
        OPC_INSERT   = 2'd0,
        OPC_CHECK    = 2'd1,
        OPC_CLEAR    = 2'd2,
        OPC_RESERVED = 2'd3
    } opcode_e;

    typedef enum logic [0:0] {
        REG_BITMAP_BITS = 1'b0,
        REG_HASH_COUNT  = 1'b1
    } cfg_reg_e;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_BYTE,
        DP_CLR_START,
        DP_CLR,
        DP_HINIT,
        DP_RD,
        DP_WORD,
        DP_K2,
        DP_H,
        DP_MIX,
        DP_FIN,
        DP_DIV1,
        DP_WAIT1,
        DP_DIV2,
        DP_WAIT2,
        DP_PINIT,
        DP_PRD,
        DP_PCHK,
        DP_RESULT
    } dp_op_e;

    typedef enum logic [1:0] {
        RES_CLEAR,
        RES_ERROR,
        RES_PLAIN,
        RES_PROBE
    } res_kind_e;

    typedef enum logic [4:0] {
        ST_RST_CLR,
        ST_IDLE,
        ST_CLR,
        ST_HINIT,
        ST_RD,
        ST_WORD,
        ST_K2,
        ST_H,
        ST_MIX,
        ST_FIN,
        ST_DIV1,
        ST_DIV1W,
        ST_DIV2,
        ST_DIV2W,
        ST_PINIT,
        ST_PRD,
        ST_PCHK,
        ST_RES
    } ctrl_state_e;

    typedef struct packed {
        dp_op_e    op;
        res_kind_e res;
    } dp_cmd_t;

    typedef struct packed {
        logic single_hash;
        logic mix_due;
        logic last_word;
        logic mix_last;
        logic fin_last;
        logic div_done;
        logic probe_last;
        logic clr_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] r);
        return (x << r) | (x >> (6'd32 - {1'b0, r}));
    endfunction

endpackage

// ----- src/bloom_filter_double_hash_core.sv -----
// Channel   Direction  Handshake           Transaction payload
// input     in         in_valid/in_stall   opcode, key_byte, last_byte
// output    out        out_valid/out_stall key_present, status, set_bit_count
// config    in         APB psel/penable    paddr, pwdata (bitmap_bits, hash_count)
//
// A key byte that does not end the key is taken without a stall. Once the key
// is received, each 32-bit word of the key is read and hashed, a lookup3 mix
// runs after each 12-byte block but the last, then come finalization, the
// two serial remainder operations, and a bitmap memory read and check per probe.
// A clear sweeps the 2048-word bitmap memory one 32-bit word per cycle, and
// the same sweep runs after reset before the first input transaction is taken.
// The input is stalled from the key end until its result is loaded into the
// output register; a held result does not block the bytes of the next key.
module bloom_filter_double_hash_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      opcode,
    input  logic [7:0]                      key_byte,
    input  logic                            last_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            key_present,
    output logic                            status,
    output logic [bfdh_pkg::COUNT_W-1:0]    set_bit_count,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import bfdh_pkg::*;

    logic [CFG_BITS_W-1:0] bits_reg;
    logic [CFG_HASH_W-1:0] hash_reg;
    logic                  cfg_write;
    dp_cmd_t               cmd;
    dp_status_t            st;

    // Configuration registers sit at byte addresses 0 and 4; bit 2 picks one.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= CFG_BITS_W'(1024);
            hash_reg <= CFG_HASH_W'(5);
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_HASH_COUNT)
            begin
                hash_reg <= pwdata[CFG_HASH_W-1:0];
            end
            else
            begin
                bits_reg <= pwdata[CFG_BITS_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_HASH_COUNT) ? 32'(hash_reg) : 32'(bits_reg);

    // The controller sequences the clear sweep, key walk, hashing, division and probing.
    bfdh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .last_byte (last_byte),
        .in_stall  (in_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // The datapath holds the key store, hash state, divider and bitmap.
    bfdh_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .cfg_bitmap_bits (bits_reg),
        .cfg_hash_count  (hash_reg),
        .opcode          (opcode),
        .key_byte        (key_byte),
        .last_byte       (last_byte),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .key_present     (key_present),
        .status          (status),
        .set_bit_count   (set_bit_count)
    );

endmodule

// ----- src/bfdh_ram.sv -----
module bfdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- src/bfdh_div.sv -----
`include "bloom_filter_double_hash_core_macros.svh"

module bfdh_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [31:0]                 dividend,
    input  logic [bfdh_pkg::SIZE_W-1:0] divisor,
    output logic                        done,
    output logic [bfdh_pkg::SIZE_W-1:0] rem
);
    import bfdh_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [31:0]       dvd_reg, dvd_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W-1:0] dvs_reg, dvs_next;
    logic [SIZE_W:0]   trial;

    // Restoring division, one quotient bit per cycle; only the remainder is kept.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, dvd_reg[31]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = SIZE_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[SIZE_W-1:0];
            end
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    `BFDH_ASSERT_IMP(a_div_rem_below_divisor, done_reg, rem_reg < dvs_reg)

endmodule

// ----- src/bfdh_datapath.sv -----
`include "bloom_filter_double_hash_core_macros.svh"

module bfdh_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bfdh_pkg::dp_cmd_t               cmd,
    output bfdh_pkg::dp_status_t            st,
    input  logic [bfdh_pkg::CFG_BITS_W-1:0] cfg_bitmap_bits,
    input  logic [bfdh_pkg::CFG_HASH_W-1:0] cfg_hash_count,
    input  logic [1:0]                      opcode,
    input  logic [7:0]                      key_byte,
    input  logic                            last_byte,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic                            key_present,
    output logic                            status,
    output logic [bfdh_pkg::COUNT_W-1:0]    set_bit_count
);
    import bfdh_pkg::*;

    logic [SIZE_W-1:0] size;
    logic [HC_W-1:0]   nhash;

    logic [KL_W-1:0]   len_reg, len_next;
    logic [KL_W-1:0]   keylen_reg, keylen_next;
    logic [1:0]        op_reg, op_next;
    logic [31:0]       word_reg, word_next;
    logic [31:0]       a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [31:0]       h_reg, h_next, k_reg, k_next;
    logic [WC_W-1:0]   w_reg, w_next;
    logic [1:0]        slot_reg, slot_next;
    logic [KL_W-1:0]   rem_reg, rem_next;
    logic [2:0]        step_reg, step_next;
    logic [SIZE_W-1:0] b1_reg, b1_next, b2_reg, b2_next;
    logic [SIZE_W-1:0] acc_reg, acc_next, pos_reg, pos_next;
    logic [HC_W-1:0]   idx_reg, idx_next;
    logic              present_reg, present_next;
    logic [SIZE_W-1:0] ones_reg, ones_next;
    logic [BM_AW-1:0]  clr_reg, clr_next;
    logic              ov_reg, ov_next;
    logic              kp_reg, kp_next, stat_reg, stat_next;
    logic [COUNT_W-1:0] cnt_out_reg, cnt_out_next;

    logic              can_store;
    logic [31:0]       new_word;
    logic [KL_W:0]     len_p3;
    logic [WC_W-1:0]   words_total;
    logic [WC_W-1:0]   words_full;

    logic              key_we;
    logic [KW_AW-1:0]  key_addr;
    logic [31:0]       key_rdata;

    logic              bm_we;
    logic [BM_AW-1:0]  bm_addr;
    logic [31:0]       bm_wdata, bm_rdata;
    logic [31:0]       bm_mask;
    logic              bm_bit;

    logic              div_start, div_done;
    logic [31:0]       div_dividend;
    logic [SIZE_W-1:0] div_rem;

    logic [SIZE_W:0]   mod_sum;
    logic [SIZE_W-1:0] mod_add;

    // Effective size and hash count after clamping to the supported range.
    always_comb
    begin
        if (cfg_bitmap_bits == '0)
        begin
            size = SIZE_W'(1);
        end
        else if (32'(cfg_bitmap_bits) > 32'(MAX_BITS))
        begin
            size = SIZE_W'(MAX_BITS);
        end
        else
        begin
            size = SIZE_W'(cfg_bitmap_bits);
        end
        if (cfg_hash_count == '0)
        begin
            nhash = HC_W'(1);
        end
        else if (32'(cfg_hash_count) > 32'(MAX_HASHES))
        begin
            nhash = HC_W'(MAX_HASHES);
        end
        else
        begin
            nhash = HC_W'(cfg_hash_count);
        end
    end

    assign can_store   = len_reg < KL_W'(MAX_KEY_BYTES);
    assign new_word    = (len_reg[1:0] == 2'd0) ? {24'b0, key_byte}
                       : (word_reg | ({24'b0, key_byte} << {len_reg[1:0], 3'b000}));
    assign len_p3      = {1'b0, keylen_reg} + (KL_W+1)'(3);
    assign words_total = len_p3[KL_W:2];
    assign words_full  = WC_W'(keylen_reg[KL_W-1:2]);

    assign key_we   = (cmd.op == DP_BYTE) && can_store;
    assign key_addr = (cmd.op == DP_BYTE) ? len_reg[KW_AW+1:2] : w_reg[KW_AW-1:0];

    bfdh_ram #(.WIDTH(32), .DEPTH(KW_DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .addr  (key_addr),
        .wdata (new_word),
        .rdata (key_rdata)
    );

    assign bm_mask  = 32'(1) << pos_reg[4:0];
    assign bm_bit   = (bm_rdata & bm_mask) != '0;
    assign bm_addr  = (cmd.op == DP_CLR) ? clr_reg : pos_reg[POS_W-1:5];
    assign bm_we    = (cmd.op == DP_CLR)
                   || ((cmd.op == DP_PCHK) && (op_reg == OPC_INSERT) && !bm_bit);
    assign bm_wdata = (cmd.op == DP_CLR) ? '0 : (bm_rdata | bm_mask);

    bfdh_ram #(.WIDTH(32), .DEPTH(BM_DEPTH)) u_bitmap_ram (
        .clk   (clk),
        .we    (bm_we),
        .addr  (bm_addr),
        .wdata (bm_wdata),
        .rdata (bm_rdata)
    );

    assign div_start    = (cmd.op == DP_DIV1) || (cmd.op == DP_DIV2);
    assign div_dividend = (cmd.op == DP_DIV1) ? c_reg : h_reg;

    bfdh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (size),
        .done     (div_done),
        .rem      (div_rem)
    );

    // Next probe offset: both operands are below the size, so one subtract suffices.
    assign mod_sum = {1'b0, acc_reg} + {1'b0, b2_reg};
    assign mod_add = (mod_sum >= {1'b0, size}) ? SIZE_W'(mod_sum - {1'b0, size})
                                               : mod_sum[SIZE_W-1:0];

    always_comb
    begin
        st.single_hash = (nhash == HC_W'(1));
        st.mix_due     = (slot_reg == 2'd2) && (rem_reg > KL_W'(12));
        st.last_word   = (w_reg == words_total - WC_W'(1));
        st.mix_last    = (step_reg == 3'd5);
        st.fin_last    = (step_reg == 3'd6);
        st.div_done    = div_done;
        st.probe_last  = (idx_reg == nhash - HC_W'(1));
        st.clr_last    = (clr_reg == '1);
        st.out_free    = !ov_reg || !out_stall;
    end

    always_comb
    begin
        logic [31:0] t;
        len_next     = len_reg;
        keylen_next  = keylen_reg;
        op_next      = op_reg;
        word_next    = word_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        h_next       = h_reg;
        k_next       = k_reg;
        w_next       = w_reg;
        slot_next    = slot_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        b1_next      = b1_reg;
        b2_next      = b2_reg;
        acc_next     = acc_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        present_next = present_reg;
        ones_next    = ones_reg;
        clr_next     = clr_reg;
        ov_next      = ov_reg && out_stall;
        kp_next      = kp_reg;
        stat_next    = stat_reg;
        cnt_out_next = cnt_out_reg;
        t            = '0;
        case (cmd.op)
            DP_BYTE:
            begin
                if (can_store)
                begin
                    word_next = new_word;
                    len_next  = len_reg + KL_W'(1);
                end
                if (last_byte)
                begin
                    keylen_next = can_store ? len_reg + KL_W'(1) : len_reg;
                    op_next     = opcode;
                    len_next    = '0;
                end
            end
            DP_CLR_START:
            begin
                len_next  = '0;
                ones_next = '0;
                clr_next  = '0;
            end
            DP_CLR:
            begin
                clr_next = clr_reg + BM_AW'(1);
            end
            DP_HINIT:
            begin
                t         = HASH_SEED + HASH_SEED + 32'(keylen_reg);
                a_next    = t;
                b_next    = t;
                c_next    = t;
                h_next    = HASH_SEED;
                w_next    = '0;
                slot_next = '0;
                rem_next  = keylen_reg;
                step_next = '0;
            end
            DP_WORD:
            begin
                case (slot_reg)
                    2'd0:    a_next = a_reg + key_rdata;
                    2'd1:    b_next = b_reg + key_rdata;
                    default: c_next = c_reg + key_rdata;
                endcase
                k_next = key_rdata * MUR_C1;
            end
            DP_K2:
            begin
                k_next = rol32(k_reg, 5'd15) * MUR_C2;
            end
            DP_H:
            begin
                if (w_reg < words_full)
                begin
                    t      = rol32(h_reg ^ k_reg, 5'd13);
                    h_next = (t << 2) + t + MUR_N;
                end
                else
                begin
                    h_next = h_reg ^ k_reg;
                end
                w_next    = w_reg + WC_W'(1);
                slot_next = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
            end
            DP_MIX:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        a_next = (a_reg - c_reg) ^ rol32(c_reg, 5'd4);
                        c_next = c_reg + b_reg;
                    end
                    3'd1:
                    begin
                        b_next = (b_reg - a_reg) ^ rol32(a_reg, 5'd6);
                        a_next = a_reg + c_reg;
                    end
                    3'd2:
                    begin
                        c_next = (c_reg - b_reg) ^ rol32(b_reg, 5'd8);
                        b_next = b_reg + a_reg;
                    end
                    3'd3:
                    begin
                        a_next = (a_reg - c_reg) ^ rol32(c_reg, 5'd16);
                        c_next = c_reg + b_reg;
                    end
                    3'd4:
                    begin
                        b_next = (b_reg - a_reg) ^ rol32(a_reg, 5'd19);
                        a_next = a_reg + c_reg;
                    end
                    default:
                    begin
                        c_next = (c_reg - b_reg) ^ rol32(b_reg, 5'd4);
                        b_next = b_reg + a_reg;
                    end
                endcase
                if (step_reg == 3'd5)
                begin
                    step_next = '0;
                    rem_next  = rem_reg - KL_W'(12);
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            DP_FIN:
            begin
                // The final lookup3 mix and the murmur finalizer run side by side.
                case (step_reg)
                    3'd0:
                    begin
                        c_next = (c_reg ^ b_reg) - rol32(b_reg, 5'd14);
                        t      = h_reg ^ 32'(keylen_reg);
                        t      = t ^ (t >> 16);
                        h_next = t * MUR_F1;
                    end
                    3'd1:
                    begin
                        a_next = (a_reg ^ c_reg) - rol32(c_reg, 5'd11);
                        t      = h_reg ^ (h_reg >> 13);
                        h_next = t * MUR_F2;
                    end
                    3'd2:
                    begin
                        b_next = (b_reg ^ a_reg) - rol32(a_reg, 5'd25);
                        h_next = h_reg ^ (h_reg >> 16);
                    end
                    3'd3: c_next = (c_reg ^ b_reg) - rol32(b_reg, 5'd16);
                    3'd4: a_next = (a_reg ^ c_reg) - rol32(c_reg, 5'd4);
                    3'd5: b_next = (b_reg ^ a_reg) - rol32(a_reg, 5'd14);
                    default: c_next = (c_reg ^ b_reg) - rol32(b_reg, 5'd24);
                endcase
                step_next = (step_reg == 3'd6) ? 3'd0 : step_reg + 3'd1;
            end
            DP_WAIT1:
            begin
                if (div_done)
                begin
                    b1_next = div_rem;
                end
            end
            DP_WAIT2:
            begin
                if (div_done)
                begin
                    b2_next = div_rem;
                end
            end
            DP_PINIT:
            begin
                acc_next     = b1_reg;
                pos_next     = b1_reg;
                idx_next     = '0;
                present_next = 1'b1;
            end
            DP_PCHK:
            begin
                if (!bm_bit)
                begin
                    present_next = 1'b0;
                    if (op_reg == OPC_INSERT)
                    begin
                        ones_next = ones_reg + SIZE_W'(1);
                    end
                end
                idx_next = idx_reg + HC_W'(1);
                if (idx_reg == '0)
                begin
                    // The second probe is bit2 itself; the running sum moves on to
                    // bit1 + bit2 so that the third probe lands on bit1 + 2 * bit2.
                    acc_next = mod_add;
                    pos_next = b2_reg;
                end
                else
                begin
                    acc_next = mod_add;
                    pos_next = mod_add;
                end
            end
            DP_RESULT:
            begin
                ov_next      = 1'b1;
                kp_next      = 1'b0;
                stat_next    = 1'b0;
                cnt_out_next = COUNT_W'(ones_reg);
                case (cmd.res)
                    RES_CLEAR: cnt_out_next = '0;
                    RES_ERROR: stat_next = 1'b1;
                    RES_PROBE: kp_next = present_reg && (op_reg == OPC_CHECK);
                    default:   kp_next = 1'b0;
                endcase
            end
            default:
            begin
                t = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            ones_reg <= '0;
            clr_reg  <= '0;
            ov_reg   <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            len_reg  <= len_next;
            ones_reg <= ones_next;
            clr_reg  <= clr_next;
            ov_reg   <= ov_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        keylen_reg  <= keylen_next;
        op_reg      <= op_next;
        word_reg    <= word_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        h_reg       <= h_next;
        k_reg       <= k_next;
        w_reg       <= w_next;
        slot_reg    <= slot_next;
        rem_reg     <= rem_next;
        b1_reg      <= b1_next;
        b2_reg      <= b2_next;
        acc_reg     <= acc_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        present_reg <= present_next;
        kp_reg      <= kp_next;
        stat_reg    <= stat_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign out_valid     = ov_reg;
    assign key_present   = kp_reg;
    assign status        = stat_reg;
    assign set_bit_count = cnt_out_reg;

    `BFDH_ASSERT_IMP(a_ones_in_range, 1'b1, 32'(ones_reg) <= 32'(MAX_BITS))
    `BFDH_ASSERT_NXT(a_result_loads_output, cmd.op == DP_RESULT, ov_reg)

endmodule

// ----- src/bfdh_ctrl.sv -----
module bfdh_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           opcode,
    input  logic                 last_byte,
    output logic                 in_stall,
    input  bfdh_pkg::dp_status_t st,
    output bfdh_pkg::dp_cmd_t    cmd
);
    import bfdh_pkg::*;

    ctrl_state_e state_reg, state_next;
    res_kind_e   res_reg, res_next;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_RST_CLR:
            begin
                if (st.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OPC_CLEAR)
                    begin
                        state_next = ST_CLR;
                    end
                    else if (last_byte)
                    begin
                        case (opcode) inside
                            OPC_INSERT, OPC_CHECK:
                            begin
                                if ((opcode == OPC_INSERT) && st.single_hash)
                                begin
                                    res_next   = RES_ERROR;
                                    state_next = ST_RES;
                                end
                                else
                                begin
                                    state_next = ST_HINIT;
                                end
                            end
                            default:
                            begin
                                res_next   = RES_PLAIN;
                                state_next = ST_RES;
                            end
                        endcase
                    end
                end
            end
            ST_CLR:
            begin
                if (st.clr_last)
                begin
                    res_next   = RES_CLEAR;
                    state_next = ST_RES;
                end
            end
            ST_HINIT: state_next = ST_RD;
            ST_RD:    state_next = ST_WORD;
            ST_WORD:  state_next = ST_K2;
            ST_K2:    state_next = ST_H;
            ST_H:
            begin
                if (st.mix_due)
                begin
                    state_next = ST_MIX;
                end
                else if (st.last_word)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_MIX:
            begin
                if (st.mix_last)
                begin
                    state_next = ST_RD;
                end
            end
            ST_FIN:
            begin
                if (st.fin_last)
                begin
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1: state_next = ST_DIV1W;
            ST_DIV1W:
            begin
                if (st.div_done)
                begin
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: state_next = ST_DIV2W;
            ST_DIV2W:
            begin
                if (st.div_done)
                begin
                    state_next = ST_PINIT;
                end
            end
            ST_PINIT: state_next = ST_PRD;
            ST_PRD:   state_next = ST_PCHK;
            ST_PCHK:
            begin
                if (st.probe_last)
                begin
                    res_next   = RES_PROBE;
                    state_next = ST_RES;
                end
                else
                begin
                    state_next = ST_PRD;
                end
            end
            ST_RES:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        cmd.op   = DP_NOP;
        cmd.res  = res_reg;
        unique case (state_reg)
            ST_RST_CLR: cmd.op = DP_CLR;
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = (opcode == OPC_CLEAR) ? DP_CLR_START : DP_BYTE;
                end
            end
            ST_CLR:   cmd.op = DP_CLR;
            ST_HINIT: cmd.op = DP_HINIT;
            ST_RD:    cmd.op = DP_RD;
            ST_WORD:  cmd.op = DP_WORD;
            ST_K2:    cmd.op = DP_K2;
            ST_H:     cmd.op = DP_H;
            ST_MIX:   cmd.op = DP_MIX;
            ST_FIN:   cmd.op = DP_FIN;
            ST_DIV1:  cmd.op = DP_DIV1;
            ST_DIV1W: cmd.op = DP_WAIT1;
            ST_DIV2:  cmd.op = DP_DIV2;
            ST_DIV2W: cmd.op = DP_WAIT2;
            ST_PINIT: cmd.op = DP_PINIT;
            ST_PRD:   cmd.op = DP_PRD;
            ST_PCHK:  cmd.op = DP_PCHK;
            ST_RES:   cmd.op = st.out_free ? DP_RESULT : DP_NOP;
            default:  cmd.op = DP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RST_CLR;
            res_reg   <= RES_PLAIN;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

endmodule
